FILE: sv/fhd_pkg.sv
// Shared types, codes and header layout constants for the frame header deframer.
package fhd_pkg;

  // Header layout, in byte offsets from the start of the frame
  localparam int unsigned HDR_BYTES     = 28;
  localparam int unsigned VERSION_AT    = 4;
  localparam int unsigned TYPE_AT       = 6;
  localparam int unsigned RESERVED_A_AT = 8;
  localparam int unsigned REQUEST_AT    = 12;
  localparam int unsigned LENGTH_AT     = 20;
  localparam int unsigned RESERVED_B_AT = 24;

  localparam int unsigned IDX_W = $clog2(HDR_BYTES);

  // Configuration register indexes
  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_MAX_LEN = 2'd2;

  // Configuration reset values
  localparam logic [31:0] MAGIC_RST   = 32'd0;
  localparam logic [15:0] VERSION_RST = 16'd1;
  localparam logic [31:0] MAX_LEN_RST = 32'd1048576;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC   = 2'd1;
  localparam logic [1:0] ST_BAD_VERSION = 2'd2;
  localparam logic [1:0] ST_TOO_LONG    = 2'd3;

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [15:0] expected_version;
    logic [31:0] max_body_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [15:0] frame_type;
    logic [63:0] req_id;
    logic [31:0] body_length;
    logic [7:0]  body_byte;
    logic        last_of_frame;
  } result_t;

endpackage

FILE: sv/fhd_if.sv
// Stream channel interfaces for received bytes and for deframer results.
interface fhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface fhd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [15:0] frame_type;
  logic [63:0] req_id;
  logic [31:0] body_length;
  logic [7:0]  body_byte;
  logic        last_of_frame;

  modport source (output valid, output kind, output status, output frame_type,
                  output req_id, output body_length, output body_byte,
                  output last_of_frame, input ready);
  modport sink   (input valid, input kind, input status, input frame_type,
                  input req_id, input body_length, input body_byte,
                  input last_of_frame, output ready);
endinterface

FILE: sv/fhd_cfg_regs.sv
// Configuration registers: magic, version and maximum body length.
module fhd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output fhd_pkg::cfg_t cfg
);
  import fhd_pkg::*;

  cfg_t cfg_r;

  // Write the addressed register; drop writes past the last index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_magic   <= MAGIC_RST;
      cfg_r.expected_version <= VERSION_RST;
      cfg_r.max_body_length  <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAGIC:   cfg_r.expected_magic   <= cfg_data;
        REG_VERSION: cfg_r.expected_version <= cfg_data[15:0];
        REG_MAX_LEN: cfg_r.max_body_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

FILE: sv/fhd_parser.sv
// Header capture, header checks and body pass-through, one byte per item.
module fhd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic [7:0]       in_byte,
  input  fhd_pkg::cfg_t    cfg,
  output logic             res_valid,
  output fhd_pkg::result_t res
);
  import fhd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_FAULT
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]      magic_r, magic_nxt;
  logic [15:0]      version_r, version_nxt;
  logic [15:0]      type_r, type_nxt;
  logic [63:0]      request_r, request_nxt;
  logic [31:0]      length_r, length_nxt;
  logic [31:0]      remain_r, remain_nxt;
  logic [1:0]       check_status;

  // Check in fixed priority: magic, version, then length
  always_comb begin
    if (magic_r != cfg.expected_magic) begin
      check_status = ST_BAD_MAGIC;
    end else if (version_r != cfg.expected_version) begin
      check_status = ST_BAD_VERSION;
    end else if (length_r > cfg.max_body_length) begin
      check_status = ST_TOO_LONG;
    end else begin
      check_status = ST_OK;
    end
  end

  // Next state and result for the accepted item
  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    magic_nxt   = magic_r;
    version_nxt = version_r;
    type_nxt    = type_r;
    request_nxt = request_r;
    length_nxt  = length_r;
    remain_nxt  = remain_r;
    res_valid   = 1'b0;
    res         = '0;
    if (in_fire) begin
      case (phase_r)
        PH_BODY: begin
          remain_nxt        = remain_r - 32'd1;
          res_valid         = 1'b1;
          res.kind          = KIND_BODY;
          res.status        = ST_OK;
          res.frame_type    = type_r;
          res.req_id        = request_r;
          res.body_length   = length_r;
          res.body_byte     = in_byte;
          res.last_of_frame = (remain_r == 32'd1);
          if (remain_r == 32'd1) begin
            phase_nxt = PH_HEADER;
            idx_nxt   = '0;
          end
        end
        PH_HEADER: begin
          // Shift the byte into the field that owns this offset
          if (idx_r < IDX_W'(VERSION_AT)) begin
            magic_nxt = {magic_r[23:0], in_byte};
          end else if (idx_r < IDX_W'(TYPE_AT)) begin
            version_nxt = {version_r[7:0], in_byte};
          end else if (idx_r < IDX_W'(RESERVED_A_AT)) begin
            type_nxt = {type_r[7:0], in_byte};
          end else if (idx_r < IDX_W'(REQUEST_AT)) begin
            // reserved bytes
          end else if (idx_r < IDX_W'(LENGTH_AT)) begin
            request_nxt = {request_r[55:0], in_byte};
          end else if (idx_r < IDX_W'(RESERVED_B_AT)) begin
            length_nxt = {length_r[23:0], in_byte};
          end
          if (idx_r != IDX_W'(HDR_BYTES - 1)) begin
            idx_nxt = idx_r + 1'b1;
          end else begin
            // Last header byte is reserved, so all fields are already held
            idx_nxt   = '0;
            res_valid = 1'b1;
            if (check_status != ST_OK) begin
              phase_nxt         = PH_FAULT;
              res.kind          = KIND_ERROR;
              res.status        = check_status;
              res.last_of_frame = 1'b1;
            end else begin
              remain_nxt     = length_r;
              res.kind       = KIND_HEADER;
              res.status     = ST_OK;
              res.frame_type = type_r;
              res.req_id     = request_r;
              if (length_r == 32'd0) begin
                phase_nxt         = PH_HEADER;
                res.last_of_frame = 1'b1;
              end else begin
                phase_nxt         = PH_BODY;
                res.body_length   = length_r;
              end
            end
          end
        end
        default: ;  // fault: drop the byte
      endcase
    end
  end

  // Hold phase, header offset and captured fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      idx_r    <= '0;
      remain_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      remain_r <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
      type_r    <= '0;
      request_r <= '0;
      length_r  <= '0;
    end else begin
      magic_r   <= magic_nxt;
      version_r <= version_nxt;
      type_r    <= type_nxt;
      request_r <= request_nxt;
      length_r  <= length_nxt;
    end
  end
endmodule

FILE: sv/fhd_result_reg.sv
// Single-entry result register that drives the result channel.
module fhd_result_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  fhd_pkg::result_t res,
  output logic             can_load,
  fhd_out_if.source        out_if
);
  import fhd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  // Free when empty or when the held item leaves this cycle
  assign can_load  = !valid_r || out_if.ready;
  assign valid_nxt = load || (valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload until a new item loads
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_if.valid         = valid_r;
  assign out_if.kind          = data_r.kind;
  assign out_if.status        = data_r.status;
  assign out_if.frame_type    = data_r.frame_type;
  assign out_if.req_id        = data_r.req_id;
  assign out_if.body_length   = data_r.body_length;
  assign out_if.body_byte     = data_r.body_byte;
  assign out_if.last_of_frame = data_r.last_of_frame;
endmodule

FILE: sv/frame_header_deframer.sv
// Frame header deframer: collects a 28-byte big-endian header (magic, version, type,
// request id, body length), checks magic, version and length against the configuration
// registers, then emits one header result followed by one result per body byte, the last
// one flagged. A failed check emits one error result and every later byte is dropped until
// reset. The block takes one byte per cycle; each result is loaded into the result register
// as the byte that causes it is accepted (the header result with the 28th header byte). The
// single-entry result register sets the rate under back-pressure: in_if.ready is low only
// while a result is held and out_if.ready is low. Write configuration while the block is idle.
module frame_header_deframer (
  input  logic        clk,
  input  logic        rst_n,
  fhd_in_if.sink      in_if,
  fhd_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fhd_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_valid;
  logic    can_load;
  logic    in_fire;

  assign in_if.ready = can_load;
  assign in_fire     = in_if.valid && can_load;

  fhd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fhd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_if.data_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  fhd_result_reg u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_valid),
    .res      (res),
    .can_load (can_load),
    .out_if   (out_if)
  );
endmodule

FILE: tb/frame_header_deframer_tb.sv
// Self-checking testbench for the frame header deframer: directed and random frames, checked against a predictor.
`timescale 1ns / 1ps

module frame_header_deframer_tb;
  import fhd_pkg::*;

  localparam int unsigned STALL_PCT  = 11;
  localparam int unsigned QUIET_MAX  = 1000;
  localparam int unsigned BYTE_GOAL  = 1100;
  localparam int unsigned NOISE_LEN  = 30;
  localparam int unsigned PRINT_CAP  = 40;
  localparam logic [1:0]  REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {RX_HEADER, RX_BODY, RX_FAULT} rx_phase_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  fhd_in_if  in_ch ();
  fhd_out_if out_ch ();

  frame_header_deframer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stream bytes still to send and results the deframer still owes
  logic [7:0] rx_bytes[$];
  result_t    predicted_results[$];

  // Shadow of the registers and of the deframer state
  cfg_t        cfg_shadow;
  rx_phase_t   rx_phase;
  int unsigned hdr_pos;
  logic [31:0] cap_magic;
  logic [15:0] cap_version;
  logic [15:0] cap_type;
  logic [63:0] cap_rid;
  logic [31:0] cap_len;
  logic [31:0] body_left;

  logic        steady;
  logic        in_taken;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned bytes_queued;
  int unsigned frames_queued;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                results_checked, name, got, want));
    end
  endtask

  // Advance the shadow deframer by one received byte
  task automatic deframe_byte(input logic [7:0] b);
    result_t    r;
    logic [1:0] st;
    r = '0;
    case (rx_phase)
      RX_BODY: begin
        body_left       = body_left - 32'd1;
        r.kind          = KIND_BODY;
        r.status        = ST_OK;
        r.frame_type    = cap_type;
        r.req_id        = cap_rid;
        r.body_length   = cap_len;
        r.body_byte     = b;
        r.last_of_frame = (body_left == 32'd0);
        if (body_left == 32'd0) begin
          rx_phase = RX_HEADER;
          hdr_pos  = 0;
        end
        predicted_results = {predicted_results, r};
      end
      RX_HEADER: begin
        // capture the field this byte belongs to; reserved bytes fall through
        if (hdr_pos < VERSION_AT) begin
          cap_magic = {cap_magic[23:0], b};
        end else if (hdr_pos < TYPE_AT) begin
          cap_version = {cap_version[7:0], b};
        end else if (hdr_pos < RESERVED_A_AT) begin
          cap_type = {cap_type[7:0], b};
        end else if (hdr_pos >= REQUEST_AT && hdr_pos < LENGTH_AT) begin
          cap_rid = {cap_rid[55:0], b};
        end else if (hdr_pos >= LENGTH_AT && hdr_pos < RESERVED_B_AT) begin
          cap_len = {cap_len[23:0], b};
        end
        if (hdr_pos + 1 < HDR_BYTES) begin
          hdr_pos++;
        end else begin
          hdr_pos = 0;
          if (cap_magic != cfg_shadow.expected_magic) begin
            st = ST_BAD_MAGIC;
          end else if (cap_version != cfg_shadow.expected_version) begin
            st = ST_BAD_VERSION;
          end else if (cap_len > cfg_shadow.max_body_length) begin
            st = ST_TOO_LONG;
          end else begin
            st = ST_OK;
          end
          if (st != ST_OK) begin
            rx_phase        = RX_FAULT;
            r.kind          = KIND_ERROR;
            r.status        = st;
            r.last_of_frame = 1'b1;
          end else begin
            body_left    = cap_len;
            r.kind       = KIND_HEADER;
            r.status     = ST_OK;
            r.frame_type = cap_type;
            r.req_id     = cap_rid;
            if (cap_len == 32'd0) begin
              r.last_of_frame = 1'b1;
            end else begin
              rx_phase      = RX_BODY;
              r.body_length = cap_len;
            end
          end
          predicted_results = {predicted_results, r};
        end
      end
      default: begin
        // sticky fault: drop the byte
      end
    endcase
  endtask

  // Compare one delivered result with the oldest prediction
  task automatic check_result();
    result_t want;
    if (predicted_results.size() == 0) begin
      report_mismatch($sformatf("result kind %0d with no item waiting", out_ch.kind));
    end else begin
      want = predicted_results.pop_front();
      check_field("kind", out_ch.kind, want.kind);
      check_field("status", out_ch.status, want.status);
      check_field("frame_type", out_ch.frame_type, want.frame_type);
      check_field("req_id", out_ch.req_id, want.req_id);
      check_field("body_length", out_ch.body_length, want.body_length);
      check_field("body_byte", out_ch.body_byte, want.body_byte);
      check_field("last_of_frame", out_ch.last_of_frame, want.last_of_frame);
    end
    results_checked++;
  endtask

  // Monitor: check results, predict accepted items, track register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_shadow.expected_magic   = MAGIC_RST;
      cfg_shadow.expected_version = VERSION_RST;
      cfg_shadow.max_body_length  = MAX_LEN_RST;
      rx_phase     = RX_HEADER;
      hdr_pos      = 0;
      cap_magic    = '0;
      cap_version  = '0;
      cap_type     = '0;
      cap_rid      = '0;
      cap_len      = '0;
      body_left    = '0;
      in_taken     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAGIC:   cfg_shadow.expected_magic   = cfg_data;
          REG_VERSION: cfg_shadow.expected_version = cfg_data[15:0];
          REG_MAX_LEN: cfg_shadow.max_body_length  = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        check_result();
      end
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.data_byte);
        void'(rx_bytes.pop_front());
      end
      in_taken <= in_ch.valid && in_ch.ready;
      // count stuck cycles only while work is outstanding
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (rx_bytes.size() != 0 || predicted_results.size() != 0) begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Driver: present the next byte, hold it until taken, idle at random
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (rx_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= STALL_PCT)) begin
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= rx_bytes[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall at random
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
  end

  initial begin
    wait (quiet_cycles >= QUIET_MAX);
    $display("Timeout: no progress for %0d cycles", QUIET_MAX);
    $display("Test completed with failures");
    $finish;
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Write all registers; junk in the upper version bits and the unused index
  task automatic set_config(input logic [31:0] magic, input logic [15:0] ver,
                            input logic [31:0] max_len);
    cfg_write(REG_MAGIC, magic);
    cfg_write(REG_VERSION, {16'($urandom()), ver});
    cfg_write(REG_MAX_LEN, max_len);
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(REG_UNUSED, $urandom());
    end
  endtask

  // Hold until every byte is taken and every result is back, then let the pipe settle
  task automatic wait_idle();
    while (rx_bytes.size() != 0 || predicted_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_bytes = {rx_bytes, b};
    bytes_queued++;
  endtask

  // Queue a big-endian header followed by nbody random body bytes
  task automatic queue_frame(input logic [31:0] magic, input logic [15:0] ver,
                             input logic [15:0] ftype, input logic [63:0] rid,
                             input logic [31:0] len, input int unsigned nbody);
    for (int i = 3; i >= 0; i--) push_byte(magic[8*i +: 8]);
    for (int i = 1; i >= 0; i--) push_byte(ver[8*i +: 8]);
    for (int i = 1; i >= 0; i--) push_byte(ftype[8*i +: 8]);
    repeat (4) push_byte(8'($urandom()));
    for (int i = 7; i >= 0; i--) push_byte(rid[8*i +: 8]);
    for (int i = 3; i >= 0; i--) push_byte(len[8*i +: 8]);
    repeat (4) push_byte(8'($urandom()));
    repeat (nbody) push_byte(8'($urandom()));
    frames_queued++;
  endtask

  // Mostly short bodies, some empty, often at the limit capped to 60, a few longer ones
  function automatic logic [31:0] pick_body_length(input logic [31:0] limit);
    logic [31:0]  top;
    int unsigned  roll;
    roll = $urandom_range(0, 99);
    top  = (limit > 32'd60) ? 32'd60 : limit;
    if (limit == 32'd0 || roll < 15) return 32'd0;
    if (roll < 30) return top;
    if (roll < 40) return $urandom_range(0, top);
    return $urandom_range(1, (top > 32'd12) ? 12 : top);
  endfunction

  function automatic logic [63:0] pick_rid();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    logic [31:0] magic;
    logic [15:0] ver;
    logic [31:0] max_len;
    logic [31:0] len;
    logic [1:0]  err_status;
    int unsigned phase_no;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_MAGIC;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    steady          = 1'b0;
    mismatches      = 0;
    results_checked = 0;
    bytes_queued    = 0;
    frames_queued   = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset register values, zero-length and short bodies, field extremes
    queue_frame(MAGIC_RST, VERSION_RST, 16'h0000, 64'h0, 32'd0, 0);
    queue_frame(MAGIC_RST, VERSION_RST, 16'hFFFF, '1, 32'd1, 1);
    queue_frame(MAGIC_RST, VERSION_RST, 16'h8001, 64'h8000_0000_0000_0001, 32'd3, 3);
    wait_idle();
    set_config(32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    queue_frame(32'hFFFF_FFFF, 16'hFFFF, 16'h0001, pick_rid(), 32'd0, 0);
    queue_frame(32'hFFFF_FFFF, 16'hFFFF, 16'h7FFE, pick_rid(), 32'd0, 0);
    wait_idle();
    set_config(32'd0, 16'd0, 32'd5);
    queue_frame(32'd0, 16'd0, 16'($urandom()), pick_rid(), 32'd5, 5);
    queue_frame(32'd0, 16'd0, 16'($urandom()), pick_rid(), 32'd0, 0);
    wait_idle();
    magic = $urandom();
    ver   = 16'($urandom());
    set_config(magic, ver, 32'hFFFF_FFFF);
    queue_frame(magic, ver, 16'($urandom()), pick_rid(), 32'd2, 2);

    // Random: well-formed frames under changing register settings
    phase_no = 0;
    while (bytes_queued < BYTE_GOAL) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0:       magic = '0;
        1:       magic = '1;
        default: magic = $urandom();
      endcase
      case ($urandom_range(0, 3))
        0:       ver = '0;
        1:       ver = '1;
        default: ver = 16'($urandom());
      endcase
      case ($urandom_range(0, 3))
        0:       max_len = '0;
        1:       max_len = '1;
        2:       max_len = $urandom_range(1, 16);
        default: max_len = $urandom();
      endcase
      set_config(magic, ver, max_len);
      steady <= (phase_no == 2 || phase_no == 3);
      repeat ($urandom_range(3, 8)) begin
        len = pick_body_length(max_len);
        queue_frame(magic, ver, 16'($urandom()), pick_rid(), len, len);
      end
      phase_no++;
    end

    // Close with one good frame, one failing frame, then bytes that must be dropped
    wait_idle();
    steady  <= 1'b0;
    magic   = $urandom();
    ver     = 16'($urandom());
    max_len = $urandom_range(0, 20);
    set_config(magic, ver, max_len);
    len = pick_body_length(max_len);
    queue_frame(magic, ver, 16'($urandom()), pick_rid(), len, len);
    case ($urandom_range(0, 2))
      0:       err_status = ST_BAD_MAGIC;
      1:       err_status = ST_BAD_VERSION;
      default: err_status = ST_TOO_LONG;
    endcase
    len = pick_body_length(max_len);
    // later checks may fail as well, the first failing one must win
    if (err_status == ST_BAD_MAGIC) begin
      if ($urandom_range(0, 1) == 0) ver = ver ^ 16'd1;
      magic = magic ^ ($urandom() | 32'd1);
    end
    if (err_status != ST_TOO_LONG) begin
      if ($urandom_range(0, 1) == 0) len = max_len + $urandom_range(1, 100);
    end
    if (err_status == ST_BAD_VERSION) begin
      ver = ver ^ (16'($urandom()) | 16'd1);
    end
    if (err_status == ST_TOO_LONG) begin
      len = max_len + $urandom_range(1, 100);
    end
    queue_frame(magic, ver, 16'($urandom()), pick_rid(), len, 0);
    repeat (NOISE_LEN) push_byte(8'($urandom()));

    // Drain, then give a stray result time to show up
    while (rx_bytes.size() != 0 || predicted_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);
    if (predicted_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
    end

    $display("Sent %0d bytes in %0d frames over %0d register settings; checked %0d results",
             bytes_queued, frames_queued, phase_no + 5, results_checked);
    $display("Run ended on a failing header with status %0d, then %0d dropped bytes",
             err_status, NOISE_LEN);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/fhd_pkg.sv
sv/fhd_if.sv
sv/fhd_cfg_regs.sv
sv/fhd_parser.sv
sv/fhd_result_reg.sv
sv/frame_header_deframer.sv
tb/frame_header_deframer_tb.sv
